// File: design/arsw_pkg.sv
`timescale 1ns / 1ps

package arsw_pkg;

	// Fixed field widths
	localparam int SEQ_W       = 24;
	localparam int WIN_W       = 6;
	localparam int BITMAP_BITS = 32;
	localparam int SHIFT_W     = $clog2(BITMAP_BITS);

	// Window register value after reset
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(32);

	// Window state carried between items
	typedef struct packed {
		logic                   seeded;
		logic [SEQ_W-1:0]       newest;
		logic [BITMAP_BITS-1:0] bitmap;
	} win_state_t;

endpackage

// File: design/arsw_check.sv
`timescale 1ns / 1ps

module arsw_check import arsw_pkg::*; (
	input  win_state_t       cur,
	input  logic [SEQ_W-1:0] seq,
	input  logic [WIN_W-1:0] limit,
	output win_state_t       nxt,
	output logic             reject
);

	logic [SEQ_W-1:0]       adv;
	logic [SEQ_W-1:0]       behind;
	logic [SHIFT_W-1:0]     adv_sh;
	logic [SHIFT_W-1:0]     behind_idx;
	logic [BITMAP_BITS-1:0] marked;
	logic [BITMAP_BITS-1:0] adv_bitmap;
	logic                   too_old;

	assign adv    = seq - cur.newest;
	assign behind = cur.newest - seq;

	// Shift the old bitmap plus a mark for the old newest by the advance;
	// an advance of the full bitmap width leaves only the old newest marked
	assign adv_sh     = SHIFT_W'(adv - SEQ_W'(1));
	assign marked     = BITMAP_BITS'({cur.bitmap, 1'b1} << adv_sh);
	assign adv_bitmap = (adv > SEQ_W'(BITMAP_BITS)) ? '0 : marked;

	assign behind_idx = SHIFT_W'(behind - SEQ_W'(1));
	assign too_old    = behind > SEQ_W'(limit);

	// Decide accept or reject and the next window state
	always_comb begin
		nxt    = cur;
		reject = 1'b0;
		priority if (!cur.seeded) begin
			nxt.seeded = 1'b1;
			nxt.newest = seq;
			nxt.bitmap = '0;
		end else if (seq > cur.newest) begin
			nxt.newest = seq;
			nxt.bitmap = adv_bitmap;
		end else if (seq == cur.newest || too_old) begin
			reject = 1'b1;
		end else if (cur.bitmap[behind_idx]) begin
			reject = 1'b1;
		end else begin
			nxt.bitmap[behind_idx] = 1'b1;
		end
	end

endmodule

// File: design/anti_replay_sliding_window.sv
`timescale 1ns / 1ps

// Anti-replay check over 24-bit sequence numbers.
// Input channel: seq_valid / seq_ready carry one seq_number per item.
// Output channel: result_valid / result_ready carry one rejected flag per
// item (0 fresh, 1 replay or too old), in input order.
// Config: cfg_wr_en with cfg_wr_data writes window_size; every
// write also re-arms the window (clears seeded flag, newest and bitmap).
// Path: the item lands in the input register when accepted, and its verdict
// in the result register when the result register advances. Throughput: one
// item per cycle while result_ready is high or the result register is empty;
// the window update is a single compare/shift step, so each item sees the
// state left by the one before it.
// Stall: when result_ready is low the result register holds; one more item
// may still be taken into the input register, after which seq_ready drops
// until the result is taken.
// Reset: window_size returns to 32, the block is unseeded and both
// registers are empty. The first number after reset or re-arm is accepted.
module anti_replay_sliding_window import arsw_pkg::*; #(
	parameter int WINDOW_MAX = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             seq_valid,
	output logic             seq_ready,
	input  logic [SEQ_W-1:0] seq_number,
	output logic             result_valid,
	input  logic             result_ready,
	output logic             rejected,
	input  logic             cfg_wr_en,
	input  logic [WIN_W-1:0] cfg_wr_data
);

	localparam logic [WIN_W:0] WMAX = (WIN_W+1)'(WINDOW_MAX);

	logic [WIN_W-1:0] window_q;
	win_state_t       state_q;
	win_state_t       state_nxt;
	logic             valid_s1;
	logic [SEQ_W-1:0] seq_s1;
	logic             out_valid_q;
	logic             rejected_q;
	logic             reject_c;
	logic             advance;
	logic [WIN_W:0]   win_clamp;
	logic [WIN_W-1:0] limit;

	// Clamp the window to 1..WINDOW_MAX and to the bitmap width
	always_comb begin
		win_clamp = {1'b0, window_q};
		if (window_q == '0)
			win_clamp = (WIN_W+1)'(1);
		if (win_clamp > WMAX)
			win_clamp = WMAX;
		if (win_clamp > (WIN_W+1)'(BITMAP_BITS))
			win_clamp = (WIN_W+1)'(BITMAP_BITS);
		limit = win_clamp[WIN_W-1:0];
	end

	assign advance   = !out_valid_q || result_ready;
	assign seq_ready = !valid_s1 || advance;

	arsw_check u_check (
		.cur    (state_q),
		.seq    (seq_s1),
		.limit  (limit),
		.nxt    (state_nxt),
		.reject (reject_c)
	);

	// Hold the window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	// Update the window state; a config write re-arms it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cfg_wr_en) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (seq_ready) begin
			valid_s1 <= seq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_ready && seq_valid) begin
			seq_s1 <= seq_number;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rejected_q <= reject_c;
		end
	end

	assign result_valid = out_valid_q;
	assign rejected     = rejected_q;

endmodule
